[src/ansi_escape_stripper_core_macros.svh]
// assertion macros shared by the escape stripper rtl
// clocked on aclk, disabled while aresetn is low; empty under synthesis
`ifndef ANSI_ESCAPE_STRIPPER_CORE_MACROS_SVH
`define ANSI_ESCAPE_STRIPPER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// property checked at every edge outside reset
`define AES_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// implication checked at every edge outside reset
`define AES_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// implication whose consequent is checked in the following cycle
`define AES_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AES_ASSERT(label, prop, msg)
`define AES_ASSERT_IMP(label, ante, cons, msg)
`define AES_ASSERT_NXT(label, ante, cons, msg)

`endif

`endif

[src/aes_pkg.sv]
// types and constants for the escape stripper
// no dependencies
`default_nettype none

package aes_pkg;

    // parser modes
    typedef enum logic [2:0] {
        MODE_PLAIN    = 3'd0,
        MODE_ESC_SEEN = 3'd1,
        MODE_CSI      = 3'd2,
        MODE_OSC      = 3'd3,
        MODE_OSC_ESC  = 3'd4
    } parse_mode_t;

    // characters the parser looks for
    localparam logic [7:0] CH_ESC       = 8'h1B;
    localparam logic [7:0] CH_BEL       = 8'h07;
    localparam logic [7:0] CH_LBRACKET  = 8'h5B;
    localparam logic [7:0] CH_RBRACKET  = 8'h5D;
    localparam logic [7:0] CH_FINAL_LO  = 8'h40;
    localparam logic [7:0] CH_FINAL_HI  = 8'h7E;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    // register port
    localparam int unsigned APB_ADDR_W = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic        REG_PASS_THROUGH = 1'b0;

    // one result item
    typedef struct packed {
        logic       keep;
        logic [7:0] out_byte;
        logic       out_last;
    } result_t;

endpackage

`default_nettype wire

[src/aes_cfg.sv]
// register port holding the pass-through setting
// depends on aes_pkg
`default_nettype none

module aes_cfg
    import aes_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic                       pass_through
);

    logic pass_through_reg;
    logic pass_through_next;
    logic wr_en;
    logic reg_hit;

    // register index is the word address
    assign reg_hit = (paddr[APB_ADDR_W-1] == REG_PASS_THROUGH);
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // write decode
    always_comb begin
        pass_through_next = pass_through_reg;
        if (wr_en && reg_hit) begin
            pass_through_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_through_reg <= 1'b0;
        end else begin
            pass_through_reg <= pass_through_next;
        end
    end

    // read back
    assign prdata = reg_hit ? {{(APB_DATA_W-1){1'b0}}, pass_through_reg} : '0;
    assign pass_through = pass_through_reg;

endmodule

`default_nettype wire

[src/aes_parser.sv]
// escape sequence parser: mode register and per-byte keep decision
// depends on aes_pkg and the assertion macro header
`default_nettype none
`include "ansi_escape_stripper_core_macros.svh"

module aes_parser
    import aes_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       in_accept,
    input  wire logic [7:0] text_byte,
    input  wire logic       end_of_text,
    input  wire logic       pass_through,
    output result_t         res
);

    parse_mode_t mode_reg;
    parse_mode_t mode_next;
    parse_mode_t mode_step;
    logic        keep;

    // next mode and keep flag for the incoming byte
    always_comb begin
        keep      = 1'b0;
        mode_step = MODE_PLAIN;
        if (pass_through) begin
            keep      = 1'b1;
            mode_step = MODE_PLAIN;
        end else begin
            case (mode_reg)
                MODE_ESC_SEEN: begin
                    if (text_byte == CH_LBRACKET) begin
                        mode_step = MODE_CSI;
                    end else if (text_byte == CH_RBRACKET) begin
                        mode_step = MODE_OSC;
                    end else begin
                        mode_step = MODE_PLAIN;
                    end
                end
                MODE_CSI: begin
                    if (text_byte inside {[CH_FINAL_LO:CH_FINAL_HI]}) begin
                        mode_step = MODE_PLAIN;
                    end else begin
                        mode_step = MODE_CSI;
                    end
                end
                MODE_OSC: begin
                    if (text_byte == CH_BEL) begin
                        mode_step = MODE_PLAIN;
                    end else if (text_byte == CH_ESC) begin
                        mode_step = MODE_OSC_ESC;
                    end else begin
                        mode_step = MODE_OSC;
                    end
                end
                MODE_OSC_ESC: begin
                    if (text_byte inside {CH_BACKSLASH, CH_BEL}) begin
                        mode_step = MODE_PLAIN;
                    end else if (text_byte == CH_ESC) begin
                        mode_step = MODE_OSC_ESC;
                    end else begin
                        mode_step = MODE_OSC;
                    end
                end
                default: begin
                    if (text_byte == CH_ESC) begin
                        mode_step = MODE_ESC_SEEN;
                    end else begin
                        keep      = 1'b1;
                        mode_step = MODE_PLAIN;
                    end
                end
            endcase
        end
    end

    // end of string drops any open sequence
    always_comb begin
        mode_next = mode_reg;
        if (in_accept) begin
            mode_next = end_of_text ? MODE_PLAIN : mode_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_PLAIN;
        end else begin
            mode_reg <= mode_next;
        end
    end

    // result for this byte
    assign res.keep     = keep;
    assign res.out_byte = keep ? text_byte : 8'h00;
    assign res.out_last = end_of_text;

    // checks
    `AES_ASSERT_NXT(a_pass_holds_plain, in_accept && pass_through, mode_reg == MODE_PLAIN,
        "parser left plain mode while pass-through was set")
    `AES_ASSERT_NXT(a_last_resets_mode, in_accept && end_of_text, mode_reg == MODE_PLAIN,
        "parser not in plain mode after end of string")
    `AES_ASSERT_IMP(a_esc_never_kept, in_accept && !pass_through && keep,
        text_byte != CH_ESC, "escape byte kept while stripping")

endmodule

`default_nettype wire

[src/aes_out_skid.sv]
// result register with a skid entry so input ready comes from a flop
// depends on aes_pkg and the assertion macro header
`default_nettype none
`include "ansi_escape_stripper_core_macros.svh"

module aes_out_skid
    import aes_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire result_t in_res,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_res
);

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    in_accept;

    assign in_ready  = !skid_valid_reg;
    assign in_accept = in_valid && in_ready;

    // main stage refills from skid first, else from the input
    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (out_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = in_accept;
                main_next       = in_res;
            end
        end else if (in_accept) begin
            skid_valid_next = 1'b1;
            skid_next       = in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload needs no reset
    always_ff @(posedge aclk) begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign out_valid = main_valid_reg;
    assign out_res   = main_reg;

    // checks
    `AES_ASSERT_IMP(a_skid_behind_main, skid_valid_reg, main_valid_reg,
        "skid entry held with empty main stage")
    `AES_ASSERT_IMP(a_skid_fill_on_stall, $rose(skid_valid_reg),
        $past(main_valid_reg && !out_ready), "skid filled without an output stall")
    `AES_ASSERT_NXT(a_out_held_on_stall, out_valid && !out_ready,
        out_valid && $stable(out_res), "result changed while the output was stalled")

endmodule

`default_nettype wire

[src/ansi_escape_stripper_core.sv]
// Escape sequence stripper: one text byte enters per clock when s_tready is high and
// is registered with a keep flag; a kept byte carries its value, a dropped byte
// reads as zero. The sustained rate is one byte per cycle while m_tready is high, set
// by the parser updating its mode for every accepted byte. The output side holds a
// result register plus one skid entry, so s_tready depends only on a flop and input
// is still taken into the skid entry when the output stalls. Write pass_through only
// while the stream is idle. s_tlast returns the parser to plain text after that byte.
// depends on aes_pkg, aes_cfg, aes_parser and aes_out_skid
`default_nettype none

module ansi_escape_stripper_core
    import aes_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [7:0]            s_tdata,   // [7:0] text_byte
    input  wire logic                  s_tlast,   // end_of_text
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [7:0]            m_tdata,   // [7:0] out_byte
    output logic      [0:0]            m_tuser,   // [0] keep
    output logic                       m_tlast,   // out_last
    // register port
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic    pass_through;
    logic    in_accept;
    result_t parse_res;
    result_t out_res;

    assign in_accept = s_tvalid && s_tready;

    // configuration register
    aes_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .pass_through (pass_through)
    );

    // mode tracking and keep decision
    aes_parser u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_accept    (in_accept),
        .text_byte    (s_tdata),
        .end_of_text  (s_tlast),
        .pass_through (pass_through),
        .res          (parse_res)
    );

    // result register and skid entry
    aes_out_skid u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_res    (parse_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata    = out_res.out_byte;
    assign m_tuser[0] = out_res.keep;
    assign m_tlast    = out_res.out_last;

endmodule

`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// testbench for ansi_escape_stripper_core: streams directed and random text through the
// stripper and checks every result against its own model of the escape parser
// depends on aes_pkg and the stripper rtl

module tb_top;
    import aes_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_BYTES   = 1550;
    localparam int HOLD_CYCLES    = 200;
    localparam int END_WAIT       = 4;
    localparam logic [APB_ADDR_W-1:0] ADDR_PASS_THROUGH = APB_ADDR_W'(4 * REG_PASS_THROUGH);

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [7:0]            s_tdata;     // [7:0] text_byte
    logic                  s_tlast;     // end_of_text
    logic                  m_tvalid;
    logic                  m_tready;
    logic [7:0]            m_tdata;     // [7:0] out_byte
    logic [0:0]            m_tuser;     // [0] keep
    logic                  m_tlast;     // out_last
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // parser model state and register copy
    parse_mode_t strip_mode;
    logic        pass_thru;

    // cleaned bytes still owed by the stripper, oldest first
    result_t     expected_q[$];

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int hold_len     = 0;

    int bytes_in     = 0;
    int bytes_kept   = 0;
    int results_seen = 0;
    int reg_writes   = 0;
    int err_count    = 0;
    int idle_cycles  = 0;

    ansi_escape_stripper_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit one_in(input int n);
        return $urandom_range(0, n - 1) == 0;
    endfunction

    // parser model: decides keep for one byte and advances the mode
    function automatic result_t strip_byte(input logic [7:0] b, input logic last);
        result_t     r;
        parse_mode_t nxt;
        logic        kp;
        kp  = 1'b0;
        nxt = MODE_PLAIN;
        if (pass_thru) begin
            kp = 1'b1;
        end else begin
            case (strip_mode)
                MODE_ESC_SEEN: begin
                    if (b == CH_LBRACKET)
                        nxt = MODE_CSI;
                    else if (b == CH_RBRACKET)
                        nxt = MODE_OSC;
                end
                MODE_CSI: begin
                    if (!(b >= CH_FINAL_LO && b <= CH_FINAL_HI))
                        nxt = MODE_CSI;
                end
                MODE_OSC: begin
                    if (b == CH_ESC)
                        nxt = MODE_OSC_ESC;
                    else if (b != CH_BEL)
                        nxt = MODE_OSC;
                end
                MODE_OSC_ESC: begin
                    if (b == CH_ESC)
                        nxt = MODE_OSC_ESC;
                    else if (b != CH_BACKSLASH && b != CH_BEL)
                        nxt = MODE_OSC;
                end
                default: begin
                    if (b == CH_ESC)
                        nxt = MODE_ESC_SEEN;
                    else
                        kp = 1'b1;
                end
            endcase
        end
        // end of string always drops back to plain text
        strip_mode = last ? MODE_PLAIN : nxt;
        r.keep     = kp;
        r.out_byte = kp ? b : 8'h00;
        r.out_last = last;
        return r;
    endfunction

    function automatic void note_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // one input transaction, with an optional random gap in front
    task automatic send_byte(input logic [7:0] b, input logic last);
        result_t pred;
        if (src_idle_en && one_in(6)) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        pred = strip_byte(b, last);
        expected_q.push_back(pred);
        bytes_in++;
        if (pred.keep)
            bytes_kept++;
    endtask

    // byte with an occasional end of string, even inside a sequence
    task automatic send_text(input logic [7:0] b);
        send_byte(b, one_in(40));
    endtask

    // stop offering and wait for every result plus the pipeline tail
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // register write: setup then access
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        reg_writes++;
    endtask

    task automatic set_pass_through(input logic v);
        wait_drained();
        write_reg(ADDR_PASS_THROUGH, {31'd0, v});
        pass_thru = v;
    endtask

    // one random piece of text: mostly well formed sequences, some noise
    task automatic send_random_segment();
        int         kind;
        int         n;
        logic [7:0] b;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            // plain run
            n = $urandom_range(1, 8);
            repeat (n) begin
                b = one_in(4) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h20, 8'h7E));
                if (b == CH_ESC)
                    b = 8'h78;
                send_text(b);
            end
        end else if (kind < 55) begin
            // csi with parameters, intermediates, a stray escape now and then
            send_text(CH_ESC);
            send_text(CH_LBRACKET);
            n = $urandom_range(0, 4);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0:       b = CH_ESC;
                    1, 2:    b = 8'($urandom_range(8'h20, 8'h2F));
                    default: b = 8'($urandom_range(8'h30, 8'h3F));
                endcase
                send_text(b);
            end
            send_text(8'($urandom_range(CH_FINAL_LO, CH_FINAL_HI)));
        end else if (kind < 75) begin
            // osc with payload and one of its terminators
            send_text(CH_ESC);
            send_text(CH_RBRACKET);
            n = $urandom_range(0, 6);
            repeat (n) begin
                if (one_in(8))
                    send_text(CH_ESC);
                b = 8'($urandom_range(8'h20, 8'h7E));
                if (b == CH_BACKSLASH)
                    b = 8'h2F;
                send_text(b);
            end
            case ($urandom_range(0, 3))
                0: send_text(CH_BEL);
                1: begin
                    send_text(CH_ESC);
                    send_text(CH_BACKSLASH);
                end
                2: begin
                    send_text(CH_ESC);
                    send_text(CH_BEL);
                end
                default: begin
                    send_text(CH_ESC);
                    send_text(CH_ESC);
                    send_text(CH_BACKSLASH);
                end
            endcase
        end else if (kind < 83) begin
            // two-byte escape
            send_text(CH_ESC);
            send_text(8'($urandom_range(0, 255)));
        end else begin
            // raw noise over the whole byte range
            n = $urandom_range(1, 6);
            repeat (n) send_text(8'($urandom_range(0, 255)));
        end
        // sometimes close the string here
        if (one_in(5))
            send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b1);
    endtask

    // extremes and every escape form
    task automatic test_directed();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        // csi with an escape inside, closed by the lowest final byte
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACKET, 1'b0);
        send_byte(8'h31, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_FINAL_LO, 1'b0);
        // csi closed by the highest final byte
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACKET, 1'b0);
        send_byte(CH_FINAL_HI, 1'b0);
        // osc: escape plus other byte continues, double escape keeps waiting
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_RBRACKET, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(8'h62, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_BACKSLASH, 1'b0);
        // osc ended by bell right after an escape
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_RBRACKET, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_BEL, 1'b0);
        // escape with an ordinary byte drops both
        send_byte(CH_ESC, 1'b0);
        send_byte(8'h41, 1'b0);
        // lone escape ending a string, then a csi cut off by end of string
        send_byte(CH_ESC, 1'b1);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACKET, 1'b1);
        send_byte(8'h7A, 1'b0);
        wait_drained();
    endtask

    // pass-through on with an open sequence, then back to stripping
    task automatic test_pass_through();
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACKET, 1'b0);
        set_pass_through(1'b1);
        repeat (20) send_random_segment();
        set_pass_through(1'b0);
        send_byte(8'h6D, 1'b0);
        send_byte(CH_ESC, 1'b0);
        send_byte(CH_LBRACKET, 1'b0);
        send_byte(8'h4B, 1'b0);
        wait_drained();
    endtask

    // long output stall with input still offered, then a full sender pause
    task automatic test_backpressure();
        int start;
        src_idle_en = 1'b0;
        hold_len    = HOLD_CYCLES;
        start       = bytes_in;
        while (bytes_in < start + 60)
            send_random_segment();
        src_idle_en = 1'b1;
        wait_drained();
        start = bytes_in;
        while (bytes_in < start + 30)
            send_random_segment();
        wait_drained();
    endtask

    // random text in phases with different register settings
    task automatic test_random();
        int target;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                1:       set_pass_through(1'b1);
                2:       set_pass_through(logic'($urandom_range(0, 1)));
                default: set_pass_through(1'b0);
            endcase
            // last phase runs with no idling on either side
            if (phase == 3) begin
                src_idle_en  = 1'b0;
                sink_idle_en = 1'b0;
            end
            target = bytes_in + RANDOM_BYTES / 4;
            while (bytes_in < target)
                send_random_segment();
        end
    endtask

    // receiver: random stall bursts and the long hold-off
    initial begin : sink
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
                m_tready <= 1'b1;
            end else if (sink_idle_en && one_in(8)) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12) - 1) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // compare each result transaction with the oldest expected one
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                note_error($sformatf("unexpected result keep %0b byte %02h last %0b",
                                     m_tuser[0], m_tdata, m_tlast));
            end else begin
                want = expected_q.pop_front();
                if (m_tuser[0] !== want.keep || m_tdata !== want.out_byte ||
                    m_tlast !== want.out_last)
                    note_error($sformatf(
                        "keep %0b/%0b byte %02h/%02h last %0b/%0b (expected/actual)",
                        want.keep, m_tuser[0], want.out_byte, m_tdata,
                        want.out_last, m_tlast));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles, %0d results outstanding",
                         idle_cycles, expected_q.size());
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial begin
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'h00;
        s_tlast  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        strip_mode = MODE_PLAIN;
        pass_thru  = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_pass_through();
        test_backpressure();
        test_random();

        wait_drained();
        repeat (END_WAIT) @(posedge aclk);
        $display("covered %0d input bytes, %0d results checked, %0d bytes kept",
                 bytes_in, results_seen, bytes_kept);
        $display("csi/osc/escape forms, end-of-string cuts, %0d register writes, long stall",
                 reg_writes);
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", err_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
